// ----- design/bdll_pkg.sv -----
// Shared types and constants for the bounded doubly linked list.
`timescale 1ns / 1ps
package bdll_pkg;
   localparam int CAPACITY = 64;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int LINK_W = IDX_W + 1;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

   typedef enum logic [2:0] {
      MODE_PUSH_BACK = 3'd0, MODE_PUSH_FRONT = 3'd1, MODE_INS_AFTER = 3'd2,
      MODE_INS_BEFORE = 3'd3, MODE_REM_FIRST = 3'd4, MODE_REM_LAST = 3'd5,
      MODE_FIND = 3'd6, MODE_CLEAR = 3'd7
   } mode_type;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef enum logic [3:0] {
      OP_NONE = 4'd0, OP_LOAD = 4'd1, OP_WALK = 4'd2, OP_LINK_NEW = 4'd3,
      OP_FIX_NEIGH = 4'd4, OP_UNLINK = 4'd5, OP_CLEAR_STEP = 4'd6,
      OP_READ_ENDS = 4'd7, OP_FREE_POP = 4'd8, OP_NEIGH_READ = 4'd9
   } op_type;

   typedef struct packed {
      op_type op;
      logic   backward;
      logic   match_walk;
      logic   capture_out;
   } cmd_type;

   typedef struct packed {
      logic pool_empty;
      logic list_empty;
      logic pos_bad;
      logic walk_done;
      logic hit;
      logic end_walk;
      logic clear_done;
      logic [2:0] mode;
   } stat_type;
endpackage

// ----- design/bdll_datapath.sv -----
// Node pool, free stack and list registers with their link updates.
`timescale 1ns / 1ps
module bdll_datapath
   import bdll_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [2:0]                mode,
   input  logic signed [31:0]        value,
   input  logic [6:0]                position,
   input  cmd_type                   cmd,
   output stat_type                  stat,
   output logic [1:0]                status_out,
   output logic                      found_out,
   output logic [6:0]                mpos_out,
   output logic [6:0]                length_out,
   output logic signed [31:0]        head_out,
   output logic signed [31:0]        tail_out
);
   logic [31:0]       val_mem [CAPACITY];
   logic [LINK_W-1:0] nxt_mem [CAPACITY];
   logic [LINK_W-1:0] prv_mem [CAPACITY];
   logic [IDX_W-1:0]  free_mem [CAPACITY];

   logic [2:0]        mode_ff;
   logic [31:0]       value_ff;
   logic [6:0]        pos_ff;
   logic [LINK_W-1:0] free_top_ff, head_ff, tail_ff, count_ff;
   logic [LINK_W-1:0] cur_ff, step_ff, new_ff, nb_ff;
   logic [31:0]       cur_val_ff, hv_ff, tv_ff;
   logic [LINK_W-1:0] cur_nxt_ff, cur_prv_ff;
   logic [1:0]        status_ff;
   logic              found_ff;
   logic [6:0]        mpos_ff;
   logic [LINK_W-1:0] clr_ff;

   logic [LINK_W-1:0] pos_eff;
   logic              ins_after;
   logic [IDX_W-1:0]  cur_i;

   assign pos_eff = (pos_ff == 7'd0) ? LINK_W'(1) : LINK_W'(pos_ff);
   assign ins_after = (mode_ff == MODE_PUSH_BACK) || (mode_ff == MODE_INS_AFTER);
   assign cur_i = cur_ff[IDX_W-1:0];

   assign stat.pool_empty = (free_top_ff == '0);
   assign stat.list_empty = (head_ff == NIL);
   assign stat.pos_bad    = (LINK_W'(pos_eff) > count_ff);
   assign stat.walk_done  = (step_ff == '0) || (cur_ff == NIL);
   assign stat.hit        = (cur_ff != NIL) && (cur_val_ff == value_ff);
   assign stat.end_walk   = (step_ff == '0) || (cur_ff == NIL);
   assign stat.clear_done = (clr_ff == LINK_W'(CAPACITY - 1));
   assign stat.mode       = mode_ff;

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         mode_ff  <= mode;
         value_ff <= value;
         pos_ff   <= position;
      end
      if (cur_ff != NIL) begin
         cur_val_ff <= val_mem[cur_i];
         cur_nxt_ff <= nxt_mem[cur_i];
         cur_prv_ff <= prv_mem[cur_i];
      end
      if (cmd.op == OP_READ_ENDS) begin
         if (cmd.capture_out) begin
            if (tail_ff != NIL) tv_ff <= val_mem[tail_ff[IDX_W-1:0]];
         end else if (head_ff != NIL) begin
            hv_ff <= val_mem[head_ff[IDX_W-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_top_ff <= LINK_W'(CAPACITY);
         head_ff     <= NIL;
         tail_ff     <= NIL;
         count_ff    <= '0;
         cur_ff      <= NIL;
         step_ff     <= '0;
         clr_ff      <= '0;
         status_ff   <= ST_OK;
         found_ff    <= 1'b0;
         mpos_ff     <= '0;
      end else begin
         unique case (cmd.op)
            OP_LOAD: begin
               status_ff <= ST_OK;
               found_ff  <= 1'b0;
               mpos_ff   <= '0;
               clr_ff    <= '0;
               if (mode == MODE_REM_LAST) begin
                  cur_ff  <= tail_ff;
                  step_ff <= count_ff;
               end else begin
                  cur_ff  <= head_ff;
                  step_ff <= count_ff;
               end
            end
            OP_WALK: begin
               if (cmd.match_walk) begin
                  if (stat.hit) begin
                     found_ff  <= 1'b1;
                     status_ff <= ST_OK;
                     mpos_ff   <= cmd.backward ? 7'(step_ff)
                                               : 7'(count_ff - step_ff + 1'b1);
                  end else begin
                     status_ff <= ST_MISS;
                     cur_ff    <= cmd.backward ? cur_prv_ff : cur_nxt_ff;
                     step_ff   <= step_ff - 1'b1;
                  end
               end else begin
                  cur_ff  <= cur_nxt_ff;
                  step_ff <= step_ff - 1'b1;
               end
            end
            OP_FREE_POP: begin
               if (stat.pool_empty) begin
                  status_ff <= ST_FULL;
               end else if ((mode_ff == MODE_INS_AFTER || mode_ff == MODE_INS_BEFORE)
                            && (stat.list_empty || stat.pos_bad)) begin
                  status_ff <= ST_MISS;
               end else begin
                  free_top_ff <= free_top_ff - 1'b1;
                  new_ff      <= LINK_W'(free_mem[IDX_W'(free_top_ff - 1'b1)]);
                  if (mode_ff == MODE_PUSH_BACK) begin
                     cur_ff  <= tail_ff;
                     step_ff <= '0;
                  end else if (mode_ff == MODE_PUSH_FRONT) begin
                     cur_ff  <= head_ff;
                     step_ff <= '0;
                  end else begin
                     cur_ff  <= head_ff;
                     step_ff <= pos_eff - 1'b1;
                  end
               end
            end
            OP_LINK_NEW: begin
               val_mem[new_ff[IDX_W-1:0]] <= value_ff;
               count_ff <= count_ff + 1'b1;
               if (cur_ff == NIL) begin
                  nxt_mem[new_ff[IDX_W-1:0]] <= NIL;
                  prv_mem[new_ff[IDX_W-1:0]] <= NIL;
                  head_ff <= new_ff;
                  tail_ff <= new_ff;
                  nb_ff   <= NIL;
               end else if (ins_after) begin
                  nxt_mem[new_ff[IDX_W-1:0]] <= cur_nxt_ff;
                  prv_mem[new_ff[IDX_W-1:0]] <= cur_ff;
                  nxt_mem[cur_i] <= new_ff;
                  nb_ff <= cur_nxt_ff;
                  if (cur_nxt_ff == NIL) tail_ff <= new_ff;
               end else begin
                  prv_mem[new_ff[IDX_W-1:0]] <= cur_prv_ff;
                  nxt_mem[new_ff[IDX_W-1:0]] <= cur_ff;
                  prv_mem[cur_i] <= new_ff;
                  nb_ff <= cur_prv_ff;
                  if (cur_prv_ff == NIL) head_ff <= new_ff;
               end
            end
            OP_FIX_NEIGH: begin
               if (nb_ff != NIL) begin
                  if (ins_after) prv_mem[nb_ff[IDX_W-1:0]] <= new_ff;
                  else nxt_mem[nb_ff[IDX_W-1:0]] <= new_ff;
               end
            end
            OP_UNLINK: begin
               if (cur_prv_ff == NIL) head_ff <= cur_nxt_ff;
               else nxt_mem[cur_prv_ff[IDX_W-1:0]] <= cur_nxt_ff;
               if (cur_nxt_ff == NIL) tail_ff <= cur_prv_ff;
               else prv_mem[cur_nxt_ff[IDX_W-1:0]] <= cur_prv_ff;
               free_mem[free_top_ff[IDX_W-1:0]] <= cur_i;
               free_top_ff <= free_top_ff + 1'b1;
               count_ff <= count_ff - 1'b1;
            end
            OP_CLEAR_STEP: begin
               free_mem[clr_ff[IDX_W-1:0]] <= clr_ff[IDX_W-1:0];
               clr_ff <= clr_ff + 1'b1;
               free_top_ff <= LINK_W'(CAPACITY);
               head_ff <= NIL;
               tail_ff <= NIL;
               count_ff <= '0;
            end
            OP_NEIGH_READ, OP_READ_ENDS, OP_NONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   assign status_out = status_ff;
   assign found_out  = found_ff;
   assign mpos_out   = mpos_ff;
   assign length_out = 7'(count_ff);
   assign head_out   = (head_ff == NIL) ? 32'sd0 : hv_ff;
   assign tail_out   = (tail_ff == NIL) ? 32'sd0 : tv_ff;
endmodule

// ----- design/bdll_control.sv -----
// Command sequencer for the linked list.
`timescale 1ns / 1ps
module bdll_control
   import bdll_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);
   typedef enum logic [11:0] {
      S_INIT  = 12'b000000000001, S_IDLE  = 12'b000000000010,
      S_START = 12'b000000000100, S_SRCH  = 12'b000000001000,
      S_POP   = 12'b000000010000, S_SEEK  = 12'b000000100000,
      S_LINK  = 12'b000001000000, S_FIX   = 12'b000010000000,
      S_UNLNK = 12'b000100000000, S_CLR   = 12'b001000000000,
      S_ENDS  = 12'b010000000000, S_OUT   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rd_ff, rd_in;
   logic      bwd;
   logic      ins_mode;

   assign bwd = (stat.mode == MODE_REM_LAST);
   assign ins_mode = (stat.mode == MODE_INS_AFTER) || (stat.mode == MODE_INS_BEFORE);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      rd_in    = 1'b0;
      cmd      = '{op: OP_NONE, backward: bwd, match_walk: 1'b0, capture_out: 1'b0};
      unique case (state_ff)
         S_INIT: begin
            cmd.op = OP_CLEAR_STEP;
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: if (req_tvalid) begin
            cmd.op = OP_LOAD;
            state_in = S_START;
         end
         S_START: begin
            case (stat.mode)
               MODE_CLEAR: state_in = S_CLR;
               MODE_REM_FIRST, MODE_REM_LAST, MODE_FIND: state_in = S_SRCH;
               default: begin
                  cmd.op = OP_FREE_POP;
                  if (stat.pool_empty || (ins_mode && (stat.list_empty || stat.pos_bad)))
                     state_in = S_ENDS;
                  else state_in = S_POP;
               end
            endcase
         end
         S_POP: begin
            state_in = S_SEEK;
         end
         S_SEEK: begin
            if (rd_ff && stat.walk_done) state_in = S_LINK;
            else if (rd_ff) begin
               cmd.op = OP_WALK;
               rd_in = 1'b0;
            end else rd_in = 1'b1;
         end
         S_LINK: begin
            cmd.op = OP_LINK_NEW;
            state_in = S_FIX;
         end
         S_FIX: begin
            cmd.op = OP_FIX_NEIGH;
            state_in = S_ENDS;
         end
         S_SRCH: begin
            if (!rd_ff) rd_in = 1'b1;
            else if (stat.hit) begin
               cmd.op = OP_WALK;
               cmd.match_walk = 1'b1;
               state_in = (stat.mode == MODE_FIND) ? S_ENDS : S_UNLNK;
            end else if (stat.end_walk) begin
               cmd.op = OP_WALK;
               cmd.match_walk = 1'b1;
               state_in = S_ENDS;
            end else begin
               cmd.op = OP_WALK;
               cmd.match_walk = 1'b1;
            end
         end
         S_UNLNK: begin
            cmd.op = OP_UNLINK;
            state_in = S_ENDS;
         end
         S_CLR: begin
            cmd.op = OP_CLEAR_STEP;
            if (stat.clear_done) state_in = S_ENDS;
         end
         S_ENDS: begin
            // The head value is read first and the tail value after it.
            cmd.op = OP_READ_ENDS;
            cmd.capture_out = rd_ff;
            if (!rd_ff) rd_in = 1'b1;
            else state_in = S_OUT;
         end
         S_OUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         rd_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_ff    <= rd_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("Response dropped while stalled.");
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("Request taken while a response is pending.");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UNLNK) |-> stat.hit)
      else $error("Unlink without a matching node.");
endmodule

// ----- design/bounded_doubly_linked_list.sv -----
// Top level of the bounded doubly linked list.
// Channel  Dir  tdata fields (low to high)
// req      in   mode[2:0] value[34:3] position[41:35], padded to 48 bits
// rsp      out  status found match_position length head_value tail_value, 88 bits
// One request at a time; a list walk reads each node and then steps to its neighbour.
// After reset the free stack is refilled before req_tready rises.
// Synchronous active-high reset empties the list; the response waits for rsp_tready,
// and a stalled response delays the next accept.
`timescale 1ns / 1ps
module bounded_doubly_linked_list
   import bdll_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // mode, value, position
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata   // status, found, match_position, length, head, tail
);
   cmd_type  cmd;
   stat_type stat;
   logic [1:0] st;
   logic fnd;
   logic [6:0] mp, len;
   logic signed [31:0] hv, tv;

   bdll_control u_ctl (.clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid,
      .rsp_tready, .stat, .cmd);

   bdll_datapath u_dp (.clock, .reset, .mode(req_tdata[2:0]),
      .value(req_tdata[34:3]), .position(req_tdata[41:35]), .cmd, .stat,
      .status_out(st), .found_out(fnd), .mpos_out(mp), .length_out(len),
      .head_out(hv), .tail_out(tv));

   assign rsp_tdata = {7'd0, tv, hv, len, mp, fnd, st};
endmodule
